### sv/pcp_pkg.sv
// ============================================================================
// pcp_pkg: shared types and constants for the pinhole camera unit
// Field widths, command and status codes, register indexes, the configuration
// bundle and the saturation and rotation-entry helpers.
// ============================================================================
`default_nettype none

package pcp_pkg;

  // Fixed field widths.
  localparam int COORD_W    = 32;
  localparam int ROT_W      = 20;
  localparam int ROT_ROW_W  = 3 * ROT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int STATUS_W   = 2;

  // Internal arithmetic widths.
  localparam int SAT_IN_W   = 66;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int CLAMP_BITS = 40;
  localparam int PROD1_W    = ROT_W + COORD_W;
  localparam int ACC1_W     = PROD1_W + 2;
  localparam int DPROD_W    = 2 * COORD_W;
  localparam int NUM_W      = 2 * COORD_W + 1;
  localparam int CT_W       = COORD_W + 2;
  localparam int PROD2_W    = ROT_W + CT_W;
  localparam int ACC2_W     = PROD2_W + 2;

  localparam logic [CLAMP_BITS:0] CLAMP_LIM = {1'b1, {CLAMP_BITS{1'b0}}};

  // Commands.
  localparam logic CMD_PROJECT   = 1'b0;
  localparam logic CMD_UNPROJECT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROT_0     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_1     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_2     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 4'd7;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One input beat after classification.
  typedef struct packed {
    logic   cmd;
    logic   ferr;
    coord_t x;
    coord_t y;
    coord_t z;
  } pcp_item_t;

  // Sideband that rides along the divider pipeline.
  typedef struct packed {
    logic       cmd;
    logic       err;
    logic       ov;
    coord_t     z;
    logic [1:0] neg;
  } pcp_side_t;

  // Configuration register bundle.
  typedef struct packed {
    logic [2:0][ROT_ROW_W-1:0] rot;
    logic [2:0][COORD_W-1:0]   trans;
    logic [CFG_DATA_W-1:0]     focal;
    logic [CFG_DATA_W-1:0]     princ;
  } pcp_cfg_t;

  typedef struct packed {
    logic   ov;
    coord_t val;
  } pcp_sat_t;

  // Saturate a wide signed value to 32 bits and flag the clip.
  function automatic pcp_sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
    pcp_sat_t r;
    logic     hi_ones;
    logic     hi_zeros;
    hi_ones  = &v[SAT_IN_W-1:COORD_W-1];
    hi_zeros = ~|v[SAT_IN_W-1:COORD_W-1];
    r.ov     = !(hi_ones || hi_zeros);
    if (r.ov) begin
      r.val = v[SAT_IN_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      r.val = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Pick one signed entry out of a packed rotation row.
  function automatic logic signed [ROT_W-1:0] rot_entry(input logic [ROT_ROW_W-1:0] row,
                                                        input int col);
    return row[col*ROT_W +: ROT_W];
  endfunction

endpackage

`default_nettype wire

### sv/pcp_in_if.sv
// ============================================================================
// pcp_in_if: input point channel
// Valid/ready channel carrying a command and three signed Q16.16 values.
// ============================================================================
`default_nettype none

interface pcp_in_if;
  import pcp_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;

  modport source (output valid, command, in_x, in_y, in_z, input ready);
  modport sink   (input valid, command, in_x, in_y, in_z, output ready);
endinterface

`default_nettype wire

### sv/pcp_out_if.sv
// ============================================================================
// pcp_out_if: result channel
// Valid/ready channel carrying three signed Q16.16 values and a status code.
// ============================================================================
`default_nettype none

interface pcp_out_if;
  import pcp_pkg::*;

  logic                valid;
  logic                ready;
  coord_t              out_x;
  coord_t              out_y;
  coord_t              out_z;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

`default_nettype wire

### sv/pcp_cfg_if.sv
// ============================================================================
// pcp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
`default_nettype none

interface pcp_cfg_if;
  import pcp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/pcp_regs.sv
// ============================================================================
// pcp_regs: configuration register file
// Holds pose and intrinsics; writes beyond the register list are dropped.
// ============================================================================
`default_nettype none

module pcp_regs #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int ROT_FRAC_BITS   = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  pcp_cfg_if.sink           cfg_port,
  output pcp_pkg::pcp_cfg_t cfg
);
  import pcp_pkg::*;

  localparam logic [ROT_ROW_W-1:0] ROT0_RST = ROT_ROW_W'(1) << ROT_FRAC_BITS;
  localparam logic [ROT_ROW_W-1:0] ROT1_RST = ROT_ROW_W'(1) << (ROT_W + ROT_FRAC_BITS);
  localparam logic [ROT_ROW_W-1:0] ROT2_RST = ROT_ROW_W'(1) << (2 * ROT_W + ROT_FRAC_BITS);
  localparam logic [CFG_DATA_W-1:0] FOCAL_RST =
    (CFG_DATA_W'(1) << (COORD_W + COORD_FRAC_BITS)) | (CFG_DATA_W'(1) << COORD_FRAC_BITS);

  pcp_cfg_t cfg_r;
  logic     wr;

  // Writes are always taken.
  assign cfg_port.ready = 1'b1;
  assign wr  = cfg_port.valid;
  assign cfg = cfg_r;

  // Register file with identity pose and unit focal lengths after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot[0] <= ROT0_RST;
      cfg_r.rot[1] <= ROT1_RST;
      cfg_r.rot[2] <= ROT2_RST;
      cfg_r.trans  <= '0;
      cfg_r.focal  <= FOCAL_RST;
      cfg_r.princ  <= '0;
    end else if (wr) begin
      case (cfg_port.index)
        REG_ROT_0:     cfg_r.rot[0]   <= cfg_port.data[ROT_ROW_W-1:0];
        REG_ROT_1:     cfg_r.rot[1]   <= cfg_port.data[ROT_ROW_W-1:0];
        REG_ROT_2:     cfg_r.rot[2]   <= cfg_port.data[ROT_ROW_W-1:0];
        REG_TRANS_X:   cfg_r.trans[0] <= cfg_port.data[COORD_W-1:0];
        REG_TRANS_Y:   cfg_r.trans[1] <= cfg_port.data[COORD_W-1:0];
        REG_TRANS_Z:   cfg_r.trans[2] <= cfg_port.data[COORD_W-1:0];
        REG_FOCAL:     cfg_r.focal    <= cfg_port.data;
        REG_PRINCIPAL: cfg_r.princ    <= cfg_port.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/pcp_front.sv
// ============================================================================
// pcp_front: input stage
// Registers each input beat and flags a zero focal length for back-projection.
// ============================================================================
`default_nettype none

module pcp_front (
  input  logic               clk,
  input  logic               rst_n,
  pcp_in_if.sink             in_port,
  input  pcp_pkg::pcp_cfg_t  cfg,
  output logic               item_valid,
  output pcp_pkg::pcp_item_t item,
  input  logic               item_ready
);
  import pcp_pkg::*;

  logic      v_r;
  logic      v_nxt;
  logic      fire;
  logic      fzero;
  pcp_item_t item_r;

  // The holding register frees up whenever the queue takes its beat.
  assign in_port.ready = !v_r || item_ready;
  assign fire          = in_port.valid && in_port.ready;
  assign v_nxt         = fire || (v_r && !item_ready);
  assign fzero         = (cfg.focal[COORD_W-1:0] == '0) ||
                         (cfg.focal[CFG_DATA_W-1:COORD_W] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Capture and classify the beat.
  always_ff @(posedge clk) begin
    if (fire) begin
      item_r.cmd  <= in_port.command;
      item_r.ferr <= (in_port.command == CMD_UNPROJECT) && fzero;
      item_r.x    <= in_port.in_x;
      item_r.y    <= in_port.in_y;
      item_r.z    <= in_port.in_z;
    end
  end

  assign item_valid = v_r;
  assign item       = item_r;

endmodule

`default_nettype wire

### sv/pcp_queue.sv
// ============================================================================
// pcp_queue: decoupling queue
// Small FIFO of classified items between the input stage and the datapath.
// ============================================================================
`default_nettype none

module pcp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  pcp_pkg::pcp_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output pcp_pkg::pcp_item_t pop_item,
  input  logic               pop_ready
);
  import pcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcp_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Occupancy never passes the depth and rises by one on a push without a pop.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

### sv/pcp_div.sv
// ============================================================================
// pcp_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, several lanes in lockstep
// with a sideband word that travels alongside.
// ============================================================================
`default_nettype none

module pcp_div #(
  parameter int LANES  = 2,
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  dividend,
  input  logic [LANES-1:0][DEN_W-1:0]  divisor,
  input  logic [SIDE_W-1:0]            side,
  output logic                         out_valid,
  output logic [LANES-1:0][NUM_W-1:0]  quotient,
  output logic [SIDE_W-1:0]            out_side
);

  logic                        vld_r  [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r  [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] den_r  [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] wrd_r  [NUM_W];
  logic [SIDE_W-1:0]           side_r [NUM_W];

  genvar k, l;
  for (k = 0; k < NUM_W; k++) begin : g_stage
    logic                        vld_in;
    logic [LANES-1:0][DEN_W-1:0] rem_in, den_in, rem_nxt;
    logic [LANES-1:0][NUM_W-1:0] wrd_in, wrd_nxt;
    logic [SIDE_W-1:0]           side_in;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign den_in  = divisor;
      assign wrd_in  = dividend;
      assign side_in = side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign wrd_in  = wrd_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Trial subtract of the shifted remainder; the quotient bit enters at the bottom.
    for (l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           fits;
      assign trial      = {rem_in[l], wrd_in[l][NUM_W-1]};
      assign diff       = trial - {1'b0, den_in[l]};
      assign fits       = trial >= {1'b0, den_in[l]};
      assign rem_nxt[l] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign wrd_nxt[l] = {wrd_in[l][NUM_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        wrd_r[k]  <= wrd_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign quotient  = wrd_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

`default_nettype wire

### sv/pcp_back.sv
// ============================================================================
// pcp_back: projection datapath
// Rotation, scaling, division and inverse rotation in a stall-together
// pipeline ending in the result register.
// ============================================================================
`default_nettype none

module pcp_back #(
  parameter int ROT_FRAC_BITS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcp_pkg::pcp_cfg_t  cfg,
  input  logic               q_valid,
  input  pcp_pkg::pcp_item_t q_item,
  output logic               q_ready,
  pcp_out_if.source          out_port
);
  import pcp_pkg::*;

  localparam int SIDE_W = $bits(pcp_side_t);

  logic adv;

  // Config slices.
  coord_t             t_v [3];
  logic [COORD_W-1:0] f_v [2];
  logic [COORD_W-1:0] pc_v [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_v[i] = coord_t'(cfg.trans[i]);
    end
    for (int l = 0; l < 2; l++) begin
      f_v[l]  = cfg.focal[l*COORD_W +: COORD_W];
      pc_v[l] = cfg.princ[l*COORD_W +: COORD_W];
    end
  end

  // The whole pipeline moves when the result register is free or drained.
  logic                out_v_r;
  coord_t              out_x_r, out_y_r, out_z_r;
  logic [STATUS_W-1:0] out_status_r;

  assign adv     = !out_v_r || out_port.ready;
  assign q_ready = adv;

  // Stage 1: forward rotation products, pixel offsets.
  coord_t                    v_in [3];
  logic signed [PROD1_W-1:0] s1_prod_nxt [3][3];
  pcp_sat_t                  s1_diff_sat [2];

  assign v_in[0] = q_item.x;
  assign v_in[1] = q_item.y;
  assign v_in[2] = q_item.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_prod_nxt[i][j] = PROD1_W'(rot_entry(cfg.rot[i], j)) * PROD1_W'(v_in[j]);
      end
    end
    for (int l = 0; l < 2; l++) begin
      s1_diff_sat[l] = sat32(SAT_IN_W'(v_in[l]) - SAT_IN_W'({1'b0, pc_v[l]}));
    end
  end

  logic                      s1_v_r, s1_cmd_r, s1_ferr_r, s1_ov_r;
  coord_t                    s1_z_r;
  logic signed [PROD1_W-1:0] s1_prod_r [3][3];
  coord_t                    s1_diff_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= q_item.cmd;
      s1_ferr_r <= q_item.ferr;
      s1_z_r    <= q_item.z;
      s1_ov_r   <= s1_diff_sat[0].ov || s1_diff_sat[1].ov;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod_r[i][j] <= s1_prod_nxt[i][j];
        end
      end
      for (int l = 0; l < 2; l++) begin
        s1_diff_r[l] <= s1_diff_sat[l].val;
      end
    end
  end

  // Stage 2: camera point for projection, depth times offset for back-projection.
  logic signed [ACC1_W-1:0]  s2_acc [3];
  pcp_sat_t                  s2_cam_sat [3];
  logic signed [DPROD_W-1:0] s2_dprod_nxt [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_acc[i]     = ACC1_W'(s1_prod_r[i][0]) + ACC1_W'(s1_prod_r[i][1]) +
                      ACC1_W'(s1_prod_r[i][2]);
      s2_cam_sat[i] = sat32(SAT_IN_W'(s2_acc[i] >>> ROT_FRAC_BITS) + SAT_IN_W'(t_v[i]));
    end
    for (int l = 0; l < 2; l++) begin
      s2_dprod_nxt[l] = DPROD_W'(s1_z_r) * DPROD_W'(s1_diff_r[l]);
    end
  end

  logic                      s2_cmd_r, s2_err_r, s2_ov_r;
  coord_t                    s2_z_r;
  coord_t                    s2_cam_r [2];
  logic signed [DPROD_W-1:0] s2_dprod_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= s1_cmd_r;
      if (s1_cmd_r == CMD_PROJECT) begin
        s2_z_r   <= s2_cam_sat[2].val;
        s2_err_r <= s2_cam_sat[2].val[COORD_W-1] || (s2_cam_sat[2].val == '0);
        s2_ov_r  <= s2_cam_sat[0].ov || s2_cam_sat[1].ov || s2_cam_sat[2].ov;
      end else begin
        s2_z_r   <= s1_z_r;
        s2_err_r <= s1_ferr_r;
        s2_ov_r  <= s1_ov_r;
      end
      for (int l = 0; l < 2; l++) begin
        s2_cam_r[l]   <= s2_cam_sat[l].val;
        s2_dprod_r[l] <= s2_dprod_nxt[l];
      end
    end
  end

  // Stage 3: dividend and divisor for both lanes.
  logic signed [NUM_W-1:0]   s3_num_nxt [2];
  logic [DIV_DEN_W-1:0]      s3_den_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (s2_cmd_r == CMD_PROJECT) begin
        s3_num_nxt[l] = NUM_W'(signed'({1'b0, f_v[l]})) * NUM_W'(s2_cam_r[l]);
        s3_den_nxt[l] = s2_z_r;
      end else begin
        s3_num_nxt[l] = NUM_W'(s2_dprod_r[l]);
        s3_den_nxt[l] = f_v[l];
      end
    end
  end

  logic                    s3_cmd_r, s3_err_r, s3_ov_r;
  coord_t                  s3_z_r;
  logic signed [NUM_W-1:0] s3_num_r [2];
  logic [DIV_DEN_W-1:0]    s3_den_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r <= s2_cmd_r;
      s3_err_r <= s2_err_r;
      s3_ov_r  <= s2_ov_r;
      s3_z_r   <= s2_z_r;
      for (int l = 0; l < 2; l++) begin
        s3_num_r[l] <= s3_num_nxt[l];
        s3_den_r[l] <= s3_den_nxt[l];
      end
    end
  end

  // Stage 4: split dividend into sign and magnitude.
  pcp_side_t            s4_side_r;
  logic [DIV_NUM_W-1:0] s4_mag_r [2];
  logic [DIV_DEN_W-1:0] s4_den_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r.cmd <= s3_cmd_r;
      s4_side_r.err <= s3_err_r;
      s4_side_r.ov  <= s3_ov_r;
      s4_side_r.z   <= s3_z_r;
      for (int l = 0; l < 2; l++) begin
        s4_side_r.neg[l] <= s3_num_r[l][NUM_W-1];
        s4_mag_r[l]      <= s3_num_r[l][NUM_W-1] ? DIV_NUM_W'(-s3_num_r[l])
                                                 : DIV_NUM_W'(s3_num_r[l]);
        s4_den_r[l]      <= s3_den_r[l];
      end
    end
  end

  // Valid bits ahead of the divider.
  logic s2_v_r, s3_v_r, s4_v_r;

  // Divider.
  logic [1:0][DIV_NUM_W-1:0] div_num;
  logic [1:0][DIV_DEN_W-1:0] div_den;
  logic [1:0][DIV_NUM_W-1:0] dq;
  logic [SIDE_W-1:0]         dside_raw;
  pcp_side_t                 dside;
  logic                      dv;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      div_num[l] = s4_mag_r[l];
      div_den[l] = s4_den_r[l];
    end
  end

  pcp_div #(
    .LANES  (2),
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s4_v_r),
    .dividend  (div_num),
    .divisor   (div_den),
    .side      (SIDE_W'(s4_side_r)),
    .out_valid (dv),
    .quotient  (dq),
    .out_side  (dside_raw)
  );

  assign dside = pcp_side_t'(dside_raw);

  // Post 1: clamp and offset for projection; camera point minus t for back-projection.
  logic [CLAMP_BITS:0]      p1_qm [2];
  pcp_sat_t                 p1_prj_sat [2];
  pcp_sat_t                 p1_cam_sat [2];
  logic signed [CT_W-1:0]   p1_ct_nxt [3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p1_qm[l] = (dq[l] > DIV_NUM_W'(CLAMP_LIM)) ? CLAMP_LIM : dq[l][CLAMP_BITS:0];
      p1_prj_sat[l] = sat32((dside.neg[l] ? -SAT_IN_W'(p1_qm[l]) : SAT_IN_W'(p1_qm[l])) +
                            SAT_IN_W'(pc_v[l]));
      p1_cam_sat[l] = sat32(dside.neg[l] ? -SAT_IN_W'(dq[l]) : SAT_IN_W'(dq[l]));
      p1_ct_nxt[l]  = CT_W'(p1_cam_sat[l].val) - CT_W'(t_v[l]);
    end
    p1_ct_nxt[2] = CT_W'(dside.z) - CT_W'(t_v[2]);
  end

  logic                   p1_v_r, p1_cmd_r, p1_err_r, p1_ov_r;
  coord_t                 p1_z_r;
  coord_t                 p1_res_r [2];
  logic signed [CT_W-1:0] p1_ct_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cmd_r <= dside.cmd;
      p1_err_r <= dside.err;
      p1_z_r   <= dside.z;
      if (dside.cmd == CMD_PROJECT) begin
        p1_ov_r <= dside.ov || p1_prj_sat[0].ov || p1_prj_sat[1].ov;
      end else begin
        p1_ov_r <= dside.ov || p1_cam_sat[0].ov || p1_cam_sat[1].ov;
      end
      for (int l = 0; l < 2; l++) begin
        p1_res_r[l] <= p1_prj_sat[l].val;
      end
      for (int i = 0; i < 3; i++) begin
        p1_ct_r[i] <= p1_ct_nxt[i];
      end
    end
  end

  // Post 2: transposed rotation products.
  logic                      p2_v_r, p2_cmd_r, p2_err_r, p2_ov_r;
  coord_t                    p2_z_r;
  coord_t                    p2_res_r [2];
  logic signed [PROD2_W-1:0] p2_prod_r [3][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_cmd_r <= p1_cmd_r;
      p2_err_r <= p1_err_r;
      p2_ov_r  <= p1_ov_r;
      p2_z_r   <= p1_z_r;
      for (int l = 0; l < 2; l++) begin
        p2_res_r[l] <= p1_res_r[l];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_prod_r[i][j] <= PROD2_W'(rot_entry(cfg.rot[i], j)) * PROD2_W'(p1_ct_r[i]);
        end
      end
    end
  end

  // Result: column sums for the world point, then status.
  logic signed [ACC2_W-1:0] w_acc [3];
  pcp_sat_t                 w_sat [3];
  coord_t                   res_x, res_y, res_z;
  logic                     res_ov;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      w_acc[j] = ACC2_W'(p2_prod_r[0][j]) + ACC2_W'(p2_prod_r[1][j]) +
                 ACC2_W'(p2_prod_r[2][j]);
      w_sat[j] = sat32(SAT_IN_W'(w_acc[j] >>> ROT_FRAC_BITS));
    end
    if (p2_cmd_r == CMD_PROJECT) begin
      res_x  = p2_err_r ? '0 : p2_res_r[0];
      res_y  = p2_err_r ? '0 : p2_res_r[1];
      res_z  = p2_z_r;
      res_ov = p2_ov_r;
    end else begin
      res_x  = p2_err_r ? '0 : w_sat[0].val;
      res_y  = p2_err_r ? '0 : w_sat[1].val;
      res_z  = p2_err_r ? '0 : w_sat[2].val;
      res_ov = p2_ov_r || w_sat[0].ov || w_sat[1].ov || w_sat[2].ov;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= res_x;
      out_y_r <= res_y;
      out_z_r <= res_z;
      if (p2_err_r) begin
        out_status_r <= STATUS_DIV_ERR;
      end else if (res_ov) begin
        out_status_r <= STATUS_SAT;
      end else begin
        out_status_r <= STATUS_OK;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      p1_v_r  <= dv;
      p2_v_r  <= p1_v_r;
      out_v_r <= p2_v_r;
    end
  end

  assign out_port.valid  = out_v_r;
  assign out_port.out_x  = out_x_r;
  assign out_port.out_y  = out_y_r;
  assign out_port.out_z  = out_z_r;
  assign out_port.status = out_status_r;

  // A divisor error always clears the first two image or world coordinates.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r == STATUS_DIV_ERR) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("error result carries nonzero coordinates");

  // A held result freezes the pipeline around it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s1_v_r) && $stable(p2_v_r) && $stable(dv)))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

### sv/pinhole_camera_project_unproject_unit.sv
// ============================================================================
// pinhole_camera_project_unproject_unit: pinhole projection and back-projection
// Projects world points to pixels through a rigid pose and intrinsics, or
// back-projects pixel plus depth to world points, in Q16.16 fixed point.
// ============================================================================
//
//   Channel   Direction  Handshake     Beat contents
//   in_port   input      valid/ready   command, in_x, in_y, in_z
//   out_port  output     valid/ready   out_x, out_y, out_z, status
//   cfg_port  input      valid/ready   index, data (register write)
//
// While no result is stalled, one beat per cycle is accepted and one result
// per cycle delivered. A result passes the input register, the queue, stages
// 1 to 4, the 64-stage radix-2 divider pipeline, post 1, post 2 and the result register.
// Reset is synchronous, active low: identity pose, unit focal lengths.
// A stalled result holds the whole back pipeline; the queue and the input
// register take up to three more beats before in_port.ready drops.
//
`default_nettype none

module pinhole_camera_project_unproject_unit #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int ROT_FRAC_BITS   = 18,
  parameter int QUEUE_DEPTH     = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  pcp_in_if.sink     in_port,
  pcp_out_if.source  out_port,
  pcp_cfg_if.sink    cfg_port
);
  import pcp_pkg::*;

  pcp_cfg_t  cfg;
  logic      f_valid, f_ready;
  pcp_item_t f_item;
  logic      q_valid, q_ready;
  pcp_item_t q_item;

  pcp_regs #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .ROT_FRAC_BITS   (ROT_FRAC_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_port (cfg_port),
    .cfg      (cfg)
  );

  pcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_port    (in_port),
    .cfg        (cfg),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  pcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  pcp_back #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .out_port (out_port)
  );

endmodule

`default_nettype wire
